### rtl/core/fbff_pkg.sv
// Package: request/response types, request kinds and sequencer states for the frame bitmap core.
package fbff_pkg;

    localparam logic [2:0] KIND_SET_BUSY = 3'd0;
    localparam logic [2:0] KIND_SET_FREE = 3'd1;
    localparam logic [2:0] KIND_TOGGLE   = 3'd2;
    localparam logic [2:0] KIND_READ     = 3'd3;
    localparam logic [2:0] KIND_FIND     = 3'd4;

    localparam logic       BIT_BUSY      = 1'b1;
    localparam logic [9:0] RESET_IN_USE  = 10'd512;

    typedef struct packed {
        logic [2:0] kind;
        logic [8:0] frame_index;
        logic [9:0] run_length;
    } t_req;

    typedef struct packed {
        logic       bit_value;
        logic       found;
        logic [8:0] run_start;
    } t_rsp;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_RMW_RD,
        S_RMW_WR,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

### rtl/core/fbff_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fbff_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/frame_bitmap_first_fit_core.sv
// Top level: frame busy bitmap with mark/toggle/read requests and first-fit free run search.
//
// Usage:
//   Request channel i_valid/o_ready/i_data carries one transaction per request:
//   kind, frame_index, run_length. Response channel o_valid/i_ready/o_data returns
//   exactly one transaction per request: bit_value, found, run_start.
//   i_cfg_we/i_cfg_wdata write frames_in_use (search limit, reset value 512);
//   write it only while no request is outstanding.
// Sequencing and throughput:
//   Mark, toggle and read requests pass from accept to o_valid through the
//   read, modify/write and result states and then the output register.
//   A find scans the bitmap RAM one frame per cycle through the run counter,
//   up to min(frames_in_use, FRAMES) frames, and skips the scan when the run
//   length is zero or above the limit. Unused kinds also skip to the result.
//   One request is in flight at a time; o_ready is high only while idle.
// Reset:
//   After i_rst_n the block sweeps the RAM to all free, one frame per cycle,
//   over every frame, with o_ready low; configuration writes are taken meanwhile.
// Stall:
//   The output register holds a result until i_ready; a new request may be
//   accepted while it waits, and its result waits in the result stage.
module frame_bitmap_first_fit_core #(
    parameter int unsigned FRAMES = 512
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  fbff_pkg::t_req i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output fbff_pkg::t_rsp o_data,
    input  logic          i_cfg_we,
    input  logic [9:0]    i_cfg_wdata
);

    localparam int unsigned AW = $clog2(FRAMES);

    fbff_pkg::t_state r_state, n_state;
    fbff_pkg::t_req   r_req, n_req;
    fbff_pkg::t_rsp   r_res, n_res;
    fbff_pkg::t_rsp   r_out, n_out;
    logic             r_ovld, n_ovld;
    logic [9:0]       r_cfg;
    logic [AW-1:0]    r_clr, n_clr;
    logic [9:0]       r_rd, n_rd;
    logic             r_first, n_first;
    logic [9:0]       r_run, n_run;

    logic          ram_we, ram_wdata, ram_re, ram_rdata;
    logic [AW-1:0] ram_waddr, ram_raddr;

    logic [9:0] lim;
    logic       accept, idx_ok, find_bad, clr_end, out_free;
    logic [9:0] run_inc;
    logic       scan_chk, scan_hit, scan_end;

    assign lim      = (32'(r_cfg) > FRAMES) ? 10'(FRAMES) : r_cfg;
    assign accept   = i_valid && o_ready;
    assign idx_ok   = 32'(r_req.frame_index) < FRAMES;
    assign find_bad = (i_data.run_length == 10'd0) || (i_data.run_length > lim);
    assign clr_end  = r_clr == AW'(FRAMES - 1);
    assign out_free = !r_ovld || i_ready;
    assign run_inc  = 10'(r_run + 10'd1);
    assign scan_chk = (r_state == fbff_pkg::S_SCAN) && !r_first;
    assign scan_hit = scan_chk && (ram_rdata != fbff_pkg::BIT_BUSY)
                      && (run_inc == r_req.run_length);
    assign scan_end = scan_chk && !scan_hit && (r_rd == lim);

    fbff_ram #(
        .WIDTH (1),
        .DEPTH (FRAMES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fbff_pkg::S_CLR: begin
                if (clr_end) n_state = fbff_pkg::S_IDLE;
            end
            fbff_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_data.kind) inside
                        fbff_pkg::KIND_SET_BUSY, fbff_pkg::KIND_SET_FREE,
                        fbff_pkg::KIND_TOGGLE, fbff_pkg::KIND_READ:
                            n_state = fbff_pkg::S_RMW_RD;
                        fbff_pkg::KIND_FIND:
                            n_state = find_bad ? fbff_pkg::S_DONE : fbff_pkg::S_SCAN;
                        default:
                            n_state = fbff_pkg::S_DONE;
                    endcase
                end
            end
            fbff_pkg::S_RMW_RD: n_state = fbff_pkg::S_RMW_WR;
            fbff_pkg::S_RMW_WR: n_state = fbff_pkg::S_DONE;
            fbff_pkg::S_SCAN: begin
                if (scan_hit || scan_end) n_state = fbff_pkg::S_DONE;
            end
            fbff_pkg::S_DONE: begin
                if (out_free) n_state = fbff_pkg::S_IDLE;
            end
            default: n_state = fbff_pkg::S_CLR;
        endcase
    end

    always_comb begin
        o_ready   = r_state == fbff_pkg::S_IDLE;
        n_req     = r_req;
        n_res     = r_res;
        n_out     = r_out;
        n_ovld    = r_ovld && !i_ready;
        n_clr     = r_clr;
        n_rd      = r_rd;
        n_first   = r_first;
        n_run     = r_run;
        ram_we    = 1'b0;
        ram_waddr = AW'(r_req.frame_index);
        ram_wdata = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = AW'(r_req.frame_index);
        unique case (r_state)
            fbff_pkg::S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = AW'(r_clr + AW'(1));
            end
            fbff_pkg::S_IDLE: begin
                if (accept) begin
                    n_req   = i_data;
                    n_res   = '0;
                    n_rd    = 10'd0;
                    n_first = 1'b1;
                    n_run   = 10'd0;
                end
            end
            fbff_pkg::S_RMW_RD: begin
                ram_re = 1'b1;
            end
            fbff_pkg::S_RMW_WR: begin
                n_res = '0;
                if (idx_ok) begin
                    unique case (r_req.kind)
                        fbff_pkg::KIND_SET_BUSY: ram_wdata = fbff_pkg::BIT_BUSY;
                        fbff_pkg::KIND_SET_FREE: ram_wdata = ~fbff_pkg::BIT_BUSY;
                        fbff_pkg::KIND_TOGGLE:   ram_wdata = ~ram_rdata;
                        default:                 ram_wdata = ram_rdata;
                    endcase
                    ram_we          = r_req.kind != fbff_pkg::KIND_READ;
                    n_res.bit_value = ram_wdata;
                end
            end
            fbff_pkg::S_SCAN: begin
                ram_re    = 1'b1;
                ram_raddr = AW'(r_rd);
                n_rd      = 10'(r_rd + 10'd1);
                n_first   = 1'b0;
                if (scan_chk) begin
                    n_run = (ram_rdata == fbff_pkg::BIT_BUSY) ? 10'd0 : run_inc;
                end
                if (scan_hit) begin
                    n_res.found     = 1'b1;
                    n_res.run_start = 9'(r_rd - r_req.run_length);
                end
            end
            fbff_pkg::S_DONE: begin
                if (out_free) begin
                    n_out  = r_res;
                    n_ovld = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbff_pkg::S_CLR;
            r_ovld  <= 1'b0;
            r_cfg   <= fbff_pkg::RESET_IN_USE;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
            r_clr   <= n_clr;
            if (i_cfg_we) r_cfg <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_res   <= n_res;
        r_out   <= n_out;
        r_rd    <= n_rd;
        r_first <= n_first;
        r_run   <= n_run;
    end

    assign o_valid = r_ovld;
    assign o_data  = r_out;

    a_run_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fbff_pkg::S_SCAN) |-> (r_run < r_req.run_length))
        else $error("free run counter reached run length without a hit");

    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.found) |-> (32'(o_data.run_start) < FRAMES))
        else $error("found run start outside the frame range");

    a_find_no_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.found) |-> !o_data.bit_value)
        else $error("find result carries a bit value");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fbff_pkg::S_SCAN) |-> (r_rd <= lim))
        else $error("scan pointer passed the search limit");

endmodule
